>>> rtl/bsvf_pkg.sv
`default_nettype none

package bsvf_pkg;

   // stack geometry
   localparam int DEPTH   = 16;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int LEVEL_W = $clog2(DEPTH + 1);
   localparam int WORD_W  = 32;
   localparam int CAP_W   = 5;
   localparam int OP_W    = 2;

   // capacity after reset
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   // opcodes; the fourth code is ignored
   localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
   localparam logic [OP_W-1:0] OP_POP    = 2'd1;
   localparam logic [OP_W-1:0] OP_FILTER = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP_WAIT,
      ST_FILT_SCAN,
      ST_FINISH
   } state_type;

   // sequencer to storage
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [WORD_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } mem_ctrl_type;

   // finished result from the sequencer
   typedef struct packed {
      logic               ok;
      logic [WORD_W-1:0]  popped_value;
      logic               is_empty;
      logic [LEVEL_W-1:0] fill_level;
   } result_type;

endpackage

`default_nettype wire

>>> rtl/bsvf_stack_ram.sv
`default_nettype none

module bsvf_stack_ram
   import bsvf_pkg::*;
(
   input  wire logic         clock,
   input  mem_ctrl_type      mem_ctrl,
   output logic [WORD_W-1:0] rd_data
);

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (mem_ctrl.wr_en) begin
         mem[mem_ctrl.wr_addr] <= mem_ctrl.wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (mem_ctrl.rd_en) begin
         rd_data_ff <= mem[mem_ctrl.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/bsvf_sequencer.sv
`default_nettype none

module bsvf_sequencer
   import bsvf_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_accept,
   input  wire logic [OP_W-1:0]     req_opcode,
   input  wire logic [WORD_W-1:0]   req_value,
   input  wire logic [CAP_W-1:0]    csr_limit,
   input  wire logic                out_free,
   input  wire logic [WORD_W-1:0]   rd_data,
   output logic                     busy,
   output logic                     fin_valid,
   output result_type               result,
   output mem_ctrl_type             mem_ctrl
);

   state_type          state_ff, state_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic [WORD_W-1:0]  key_ff, key_in;
   logic [LEVEL_W-1:0] rd_idx_ff, rd_idx_in;
   logic [LEVEL_W-1:0] keep_ff, keep_in;
   logic [LEVEL_W-1:0] cnt_ff, cnt_in;
   logic               ok_ff, ok_in;
   logic [WORD_W-1:0]  popped_ff, popped_in;

   logic [LEVEL_W-1:0] limit_eff;
   logic [LEVEL_W-1:0] keep_next;
   logic               match;

   // clamp capacity to the storage depth
   assign limit_eff = (csr_limit > CAP_W'(DEPTH)) ? LEVEL_W'(DEPTH) : LEVEL_W'(csr_limit);

   // single compare unit: stored word against the filter key
   assign match = (rd_data == key_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_opcode == OP_POP && level_ff != '0) begin
                  state_in = ST_POP_WAIT;
               end else if (req_opcode == OP_FILTER && level_ff != '0) begin
                  state_in = ST_FILT_SCAN;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_POP_WAIT: begin
            state_in = ST_FINISH;
         end
         ST_FILT_SCAN: begin
            if (cnt_ff == LEVEL_W'(1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and storage control
   always_comb begin
      level_in         = level_ff;
      key_in           = key_ff;
      rd_idx_in        = rd_idx_ff;
      keep_in          = keep_ff;
      cnt_in           = cnt_ff;
      ok_in            = ok_ff;
      popped_in        = popped_ff;
      keep_next        = keep_ff + LEVEL_W'(1);
      mem_ctrl.wr_en   = 1'b0;
      mem_ctrl.wr_addr = '0;
      mem_ctrl.wr_data = rd_data;
      mem_ctrl.rd_en   = 1'b0;
      mem_ctrl.rd_addr = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               ok_in     = 1'b0;
               popped_in = '0;
               case (req_opcode)
                  OP_PUSH: begin
                     // store on top unless at or above the limit
                     if (level_ff < limit_eff) begin
                        mem_ctrl.wr_en   = 1'b1;
                        mem_ctrl.wr_addr = level_ff[ADDR_W-1:0];
                        mem_ctrl.wr_data = req_value;
                        level_in         = level_ff + LEVEL_W'(1);
                        ok_in            = 1'b1;
                     end
                  end
                  OP_POP: begin
                     // read the top word, drop the level
                     if (level_ff != '0) begin
                        mem_ctrl.rd_en   = 1'b1;
                        mem_ctrl.rd_addr = ADDR_W'(level_ff - LEVEL_W'(1));
                        level_in         = level_ff - LEVEL_W'(1);
                        ok_in            = 1'b1;
                     end
                  end
                  OP_FILTER: begin
                     // start the scan at the bottom entry
                     ok_in   = 1'b1;
                     key_in  = req_value;
                     keep_in = '0;
                     if (level_ff != '0) begin
                        mem_ctrl.rd_en   = 1'b1;
                        mem_ctrl.rd_addr = '0;
                        rd_idx_in        = LEVEL_W'(1);
                        cnt_in           = level_ff;
                     end
                  end
                  default: begin
                     ok_in = 1'b0;
                  end
               endcase
            end
         end
         ST_POP_WAIT: begin
            popped_in = rd_data;
         end
         ST_FILT_SCAN: begin
            // compact survivors downward, fetch the next entry unless this is the last
            if (!match) begin
               mem_ctrl.wr_en   = 1'b1;
               mem_ctrl.wr_addr = keep_ff[ADDR_W-1:0];
               mem_ctrl.wr_data = rd_data;
               keep_in          = keep_next;
            end
            if (cnt_ff == LEVEL_W'(1)) begin
               level_in = match ? keep_ff : keep_next;
            end else begin
               mem_ctrl.rd_en   = 1'b1;
               mem_ctrl.rd_addr = rd_idx_ff[ADDR_W-1:0];
               rd_idx_in        = rd_idx_ff + LEVEL_W'(1);
               cnt_in           = cnt_ff - LEVEL_W'(1);
            end
         end
         ST_FINISH: begin
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         level_ff <= '0;
      end else begin
         state_ff <= state_in;
         level_ff <= level_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      key_ff    <= key_in;
      rd_idx_ff <= rd_idx_in;
      keep_ff   <= keep_in;
      cnt_ff    <= cnt_in;
      ok_ff     <= ok_in;
      popped_ff <= popped_in;
   end

   assign busy                = (state_ff != ST_IDLE);
   assign fin_valid           = (state_ff == ST_FINISH);
   assign result.ok           = ok_ff;
   assign result.popped_value = popped_ff;
   assign result.is_empty     = (level_ff == '0);
   assign result.fill_level   = level_ff;

endmodule

`default_nettype wire

>>> rtl/bounded_stack_with_value_filter_top.sv
`default_nettype none

// Bounded LIFO stack of 16 signed 32-bit words with a value filter. Each request
// beat carries an opcode (push, pop, filter) and a value and yields exactly one
// response beat with ok, the popped word, an empty flag and the fill level after
// the operation. One request is in flight at a time: a push, an ignored code or a
// pop on an empty stack goes straight to the finish state, any other pop first
// waits for the registered read of the storage port, and a filter scans from the bottom
// entry up, since a single compare unit walks the stored words one per cycle and
// compacts survivors in place through the one write port. A request can be taken
// while the previous response still waits in the output register; a finished
// result then holds the block, with the request side stalled, for every cycle
// that register stays stalled. The capacity register (reset 16, values above 16
// act as 16) refuses pushes at or above its level; write it only idle.

module bounded_stack_with_value_filter_top
   import bsvf_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [OP_W-1:0]     req_opcode,
   input  wire logic signed [WORD_W-1:0] req_value,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic                     rsp_ok,
   output logic signed [WORD_W-1:0] rsp_popped_value,
   output logic                     rsp_is_empty,
   output logic [LEVEL_W-1:0]       rsp_fill_level,
   input  wire logic                csr_wr_en,
   input  wire logic [CAP_W-1:0]    csr_wr_data
);

   logic [CAP_W-1:0]  csr_limit_ff;
   logic              busy;
   logic              fin_valid;
   logic              out_free;
   logic              req_accept;
   logic              rsp_load;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        result;
   result_type        rsp_ff;
   mem_ctrl_type      mem_ctrl;
   logic [WORD_W-1:0] rd_data;

   // capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_limit_ff <= CAP_RESET;
      end else if (csr_wr_en) begin
         csr_limit_ff <= csr_wr_data;
      end
   end

   assign req_stall  = busy;
   assign req_accept = req_valid && !busy;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_load   = fin_valid && out_free;

   bsvf_sequencer u_sequencer (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_opcode (req_opcode),
      .req_value  (req_value),
      .csr_limit  (csr_limit_ff),
      .out_free   (out_free),
      .rd_data    (rd_data),
      .busy       (busy),
      .fin_valid  (fin_valid),
      .result     (result),
      .mem_ctrl   (mem_ctrl)
   );

   bsvf_stack_ram u_stack_ram (
      .clock    (clock),
      .mem_ctrl (mem_ctrl),
      .rd_data  (rd_data)
   );

   // hold the response beat until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ok           = rsp_ff.ok;
   assign rsp_popped_value = rsp_ff.popped_value;
   assign rsp_is_empty     = rsp_ff.is_empty;
   assign rsp_fill_level   = rsp_ff.fill_level;

endmodule

`default_nettype wire
